### design/itfr_pkg.sv
// Package for the idle-timeout frame receiver.
// Holds the word opcodes, the controller state type and the register reset value.
// No dependencies; every other file of the block depends on it.
package itfr_pkg;

	// Kind of word on the receive channel.
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	// Controller states: taking words, or reading a closed frame out of the store.
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	localparam logic [7:0] IDLE_LIMIT_RESET = 8'd10;

endpackage : itfr_pkg

### design/itfr_if.sv
// Channel interfaces of the idle-timeout frame receiver.
// itfr_in_if carries received bytes and ticks, itfr_out_if carries frame bytes.
// Depends on itfr_pkg for the opcode type.
interface itfr_in_if;
	logic              valid;
	logic              ready;
	itfr_pkg::opcode_t opcode;
	logic [7:0]        rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface : itfr_in_if

interface itfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface : itfr_out_if

### design/idle_timeout_frame_receiver_top.sv
// Idle-timeout frame receiver: received bytes are written into a frame store, and
// periodic tick words watch the line. A tick that finds new bytes since the last
// tick restarts the idle count; a tick that finds none raises it, and once the
// count exceeds idle_limit the buffered frame is sent out on frame_out in arrival
// order, frame_last marking the final byte. Should the count of stored bytes pass
// BUFFER_DEPTH - GUARD_MARGIN, the partial frame is silently dropped. A byte word
// or a tick word that closes no frame keeps rx_in.ready high, and a new word is
// taken in the very next cycle. A tick that closes a frame holds rx_in.ready low
// until the frame is read, one read per cycle through the store's single read port
// while frame_out does not stall. The last byte or two of a frame may still sit in
// the read and output registers when rx_in.ready returns. idle_limit resets to 10;
// the user must write it through cfg_we / cfg_wdata only while the block is idle,
// which the block does not enforce. A value of 255 never closes a frame. The frame
// store needs no clearing after reset: a frame only reads entries written for it.
module idle_timeout_frame_receiver_top #(
	parameter int BUFFER_DEPTH = 64,
	parameter int GUARD_MARGIN = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	itfr_in_if.sink         rx_in,
	itfr_out_if.source      frame_out,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata
);
	import itfr_pkg::*;

	// The count never exceeds the fill limit, which is below the depth, so the
	// store address width also holds every count value.
	localparam int CNT_W      = $clog2(BUFFER_DEPTH);
	localparam int FILL_LIMIT = BUFFER_DEPTH - GUARD_MARGIN;

	// Frame store: one write port for received bytes, one registered read port.
	logic [7:0]       frame_store [BUFFER_DEPTH];

	// Receive-side state.
	logic [CNT_W-1:0] byte_count_q;
	logic [CNT_W-1:0] last_seen_q;
	logic [7:0]       idle_ticks_q;
	logic [7:0]       idle_limit_q;

	// Drain sequencer and read pipeline.
	state_t           state_q;
	state_t           state_next;
	logic [CNT_W-1:0] rd_addr_q;
	logic             rd_valid_s1;
	logic             rd_last_s1;
	logic [7:0]       rd_data_s1;

	// Output register in front of frame_out.
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             in_ready;
	logic             drain_active;
	logic             word_taken;
	logic             byte_taken;
	logic             tick_taken;
	logic [CNT_W:0]   count_inc;
	logic             count_overflow;
	logic [7:0]       idle_inc;
	logic             frame_close;
	logic [CNT_W-1:0] last_idx;
	logic             rd_issue;
	logic             rd_final;
	logic             s1_move;

	// Words are accepted only while no frame is being read out, so the store
	// never sees a write and a read of the same entry in one cycle.
	assign word_taken = rx_in.valid && in_ready;
	assign byte_taken = word_taken && (rx_in.opcode == OP_BYTE);
	assign tick_taken = word_taken && (rx_in.opcode == OP_TICK);

	assign count_inc      = {1'b0, byte_count_q} + (CNT_W + 1)'(1);
	assign count_overflow = count_inc > (CNT_W + 1)'(FILL_LIMIT);

	// The idle counter wraps at 256, so with a limit of 255 it never closes a frame.
	assign idle_inc    = idle_ticks_q + 8'd1;
	assign frame_close = tick_taken && (byte_count_q != '0) &&
	                     (byte_count_q == last_seen_q) && (idle_inc > idle_limit_q);

	// The frame length is the recorded count, which stays put during the drain.
	assign last_idx = last_seen_q - CNT_W'(1);
	assign rd_final = (rd_addr_q == last_idx);

	// A read may issue when the read stage is empty or hands its byte on this cycle.
	assign s1_move  = rd_valid_s1 && (!out_valid_q || frame_out.ready);
	assign rd_issue = drain_active && (!rd_valid_s1 || s1_move);

	// Next-state logic of the drain sequencer.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (frame_close) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (rd_issue && rd_final) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Output decode of the drain sequencer.
	always_comb begin
		in_ready     = 1'b0;
		drain_active = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready     = 1'b1;
			ST_DRAIN: drain_active = 1'b1;
			default: begin
				in_ready     = 1'b0;
				drain_active = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (cfg_we) begin
			idle_limit_q <= cfg_wdata;
		end
	end

	// Byte count, recorded count and idle counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			last_seen_q  <= '0;
			idle_ticks_q <= '0;
		end else if (byte_taken) begin
			// Passing the fill limit throws the partial frame away.
			if (count_overflow) begin
				byte_count_q <= '0;
			end else begin
				byte_count_q <= count_inc[CNT_W-1:0];
			end
		end else if (tick_taken && (byte_count_q != '0)) begin
			if (byte_count_q != last_seen_q) begin
				last_seen_q  <= byte_count_q;
				idle_ticks_q <= '0;
			end else if (idle_inc > idle_limit_q) begin
				// The recorded count is kept; it sets the length of the drain.
				byte_count_q <= '0;
				idle_ticks_q <= '0;
			end else begin
				idle_ticks_q <= idle_inc;
			end
		end
	end

	// Frame store write and read ports.
	always_ff @(posedge clk) begin
		if (byte_taken) begin
			frame_store[byte_count_q] <= rx_in.rx_byte;
		end
		if (rd_issue) begin
			rd_data_s1 <= frame_store[rd_addr_q];
		end
	end

	// Read address walks the frame from entry zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
		end else if (frame_close) begin
			rd_addr_q <= '0;
		end else if (rd_issue) begin
			rd_addr_q <= rd_addr_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (rd_issue) begin
			rd_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			rd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_last_s1 <= rd_final;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_byte_q <= rd_data_s1;
			out_last_q <= rd_last_s1;
		end
	end

	assign rx_in.ready          = in_ready;
	assign frame_out.valid      = out_valid_q;
	assign frame_out.frame_byte = out_byte_q;
	assign frame_out.frame_last = out_last_q;

endmodule : idle_timeout_frame_receiver_top

### design/itfr_checker.sv
// Port-level checker for the idle-timeout frame receiver.
// Watches the channel handshakes of the top level; bound to it below.
// Depends on itfr_pkg for the opcode values.
module itfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_opcode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);
	import itfr_pkg::*;

	// A stalled frame word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("frame word changed while stalled");

	// Only a tick can start a frame drain, so a byte word never drops ready.
	a_byte_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == OP_BYTE) |=> in_ready)
		else $error("ready dropped after a byte word");

	// Ready falls only right after an accepted tick.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && (in_opcode == OP_TICK)))
		else $error("ready fell without a tick word");

endmodule : itfr_checker

bind idle_timeout_frame_receiver_top itfr_checker u_itfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (rx_in.valid),
	.in_ready  (rx_in.ready),
	.in_opcode (rx_in.opcode),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.out_byte  (frame_out.frame_byte),
	.out_last  (frame_out.frame_last)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for idle_timeout_frame_receiver_top, built on itfr_pkg and the
// itfr_in_if / itfr_out_if channel interfaces; byte and tick words go in, and every frame
// word that comes out is checked against a cycle-free prediction of the receiver.
module tb;
	import itfr_pkg::*;

	localparam int BUFFER_DEPTH   = 64;
	localparam int GUARD_MARGIN   = 10;
	localparam int ADDR_W         = $clog2(BUFFER_DEPTH);
	// Highest count of stored bytes that survives; one more drops the partial frame.
	localparam int FILL_LIMIT     = BUFFER_DEPTH - GUARD_MARGIN;
	// Cycles the output side refuses frame words when a long hold-off is asked for.
	localparam int HOLD_CYCLES    = 400;
	// Cycles allowed for the block to settle after the last expected word has arrived.
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	// Longest run of cycles with no word moving on either channel before giving up.
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	itfr_in_if  rx_if ();
	itfr_out_if frame_if ();

	idle_timeout_frame_receiver_top #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.GUARD_MARGIN(GUARD_MARGIN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx_in(rx_if),
		.frame_out(frame_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Words waiting to be offered on rx_in, and frame words the receiver still owes us.
	rx_word_t    word_q[$];
	frame_word_t frame_expect_q[$];

	// Private copy of the receiver state, advanced once per accepted rx_in word.
	logic [7:0] frame_mem [BUFFER_DEPTH];
	logic [6:0] held_count     = '0;
	logic [6:0] seen_count     = '0;
	logic [7:0] idle_run       = '0;
	logic [7:0] idle_limit_now = IDLE_LIMIT_RESET;

	int  mismatch_count = 0;
	int  queued_items   = 0;
	int  stall_watch    = 0;
	// The stimulus process bumps hold_asks; the output process serves each ask once.
	int  hold_asks      = 0;
	int  holds_served   = 0;
	bit  idling         = 1'b1;
	bit  offering       = 1'b0;
	int  gap_left       = 0;
	int  stall_left     = 0;
	int  hold_left      = 0;
	rx_word_t cur_word;

	// Clock: 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Every input of the block holds a known value from time zero, and reset is
	// released away from the rising edge so the first active edge is clean.
	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		rx_if.valid      = 1'b0;
		rx_if.opcode     = OP_BYTE;
		rx_if.rx_byte    = '0;
		frame_if.ready   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Advances the predicted receiver by one accepted word and queues any frame it closes.
	function automatic void collect_frame_word(rx_word_t w);
		int n;
		if (w.opcode == OP_BYTE) begin
			if (int'(held_count) < BUFFER_DEPTH)
				frame_mem[held_count[ADDR_W-1:0]] = w.rx_byte;
			held_count = held_count + 7'd1;
			// Guard overflow: the partial frame is dropped, the recorded count stays.
			if (int'(held_count) > FILL_LIMIT)
				held_count = '0;
			return;
		end
		if (held_count == '0)
			return;
		if (seen_count != held_count) begin
			seen_count = held_count;
			idle_run   = '0;
			return;
		end
		// The idle run wraps at 256, so a limit of 255 is never exceeded.
		idle_run = idle_run + 8'd1;
		if (idle_run <= idle_limit_now)
			return;
		idle_run   = '0;
		held_count = '0;
		n = (int'(seen_count) > FILL_LIMIT) ? FILL_LIMIT : int'(seen_count);
		for (int k = 0; k < n; k++)
			frame_expect_q.push_back('{frame_byte: frame_mem[ADDR_W'(k)],
				frame_last: (k == n - 1)});
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] frame_out mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic queue_word(opcode_t op, logic [7:0] value);
		word_q.push_back('{opcode: op, rx_byte: value});
		queued_items++;
	endtask

	// Register writes go in only while the block is quiet, so the predicted limit can
	// change at the same moment without racing any accepted word.
	task automatic write_idle_limit(logic [7:0] value);
		@(posedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		idle_limit_now = value;
	endtask

	// Holds the stimulus until every queued word is taken and every owed frame word
	// has come out, then lets the block finish any word that produced nothing.
	task automatic wait_for_frames();
		while (word_q.size() != 0 || offering)
			@(posedge clk);
		while (frame_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One frame with random content. Most are short, some run up to the guard limit,
	// a few overflow it. Stray ticks between bytes record the count mid-frame, and
	// some frames get too few closing ticks so the next one continues them.
	task automatic queue_random_frame();
		int len;
		int pick;
		int closing;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			len = $urandom_range(1, 8);
		else if (pick < 8)
			len = $urandom_range(9, FILL_LIMIT);
		else if (pick == 8)
			len = FILL_LIMIT;
		else
			len = $urandom_range(FILL_LIMIT + 1, FILL_LIMIT + 6);
		for (int k = 0; k < len; k++) begin
			queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 7) == 0)
				queue_word(OP_TICK, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 4) == 0)
			closing = $urandom_range(0, int'(idle_limit_now));
		else
			closing = int'(idle_limit_now) + 2;
		// Now and then a few extra ticks follow; those on an empty buffer must do nothing.
		if ($urandom_range(0, 5) == 0)
			closing += $urandom_range(1, 4);
		repeat (closing) queue_word(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// Sender: offers the oldest pending word and keeps valid up until it is taken.
	// Random gaps follow some accepted words while idling is on.
	always @(posedge clk) begin
		if (!arst_n) begin
			offering    = 1'b0;
			gap_left    = 0;
			rx_if.valid <= 1'b0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				collect_frame_word(cur_word);
				offering = 1'b0;
				if (idling && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 16);
			end
			if (!offering) begin
				if (gap_left > 0)
					gap_left--;
				else if (word_q.size() != 0) begin
					cur_word = word_q.pop_front();
					offering = 1'b1;
				end
			end
			rx_if.valid   <= offering;
			rx_if.opcode  <= cur_word.opcode;
			rx_if.rx_byte <= cur_word.rx_byte;
		end
	end

	// Receiver readiness: random stalls, plus a long hold-off on request so that a frame
	// drain backs up into the input channel.
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
		end else begin
			if (hold_asks != holds_served) begin
				holds_served = holds_served + 1;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				frame_if.ready <= 1'b0;
			end else begin
				frame_if.ready <= 1'b1;
				if (idling && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 16);
			end
		end
	end

	// Checker: every frame word taken from frame_out must match the oldest expectation.
	always @(posedge clk) begin : frame_check
		frame_word_t due;
		if (arst_n && frame_if.valid && frame_if.ready) begin
			if (frame_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word byte=%02h last=%b",
					frame_if.frame_byte, frame_if.frame_last));
			end else begin
				due = frame_expect_q.pop_front();
				if (frame_if.frame_byte !== due.frame_byte)
					report_mismatch($sformatf("frame_byte %02h, expected %02h",
						frame_if.frame_byte, due.frame_byte));
				if (frame_if.frame_last !== due.frame_last)
					report_mismatch($sformatf("frame_last %b, expected %b (byte %02h)",
						frame_if.frame_last, due.frame_last, due.frame_byte));
			end
		end
	end

	// Watchdog: a long run of cycles with no word moving on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready))
				stall_watch = 0;
			else
				stall_watch++;
			if (stall_watch >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin : stimulus
		logic [7:0] random_limits [4];
		int goal;

		random_limits[0] = 8'd1;
		random_limits[1] = 8'd3;
		random_limits[2] = 8'($urandom_range(0, 20));
		random_limits[3] = 8'd0;

		while (!arst_n)
			@(posedge clk);

		// Directed, at the reset limit of 10: a tick on an empty buffer does nothing,
		// then four bytes at the extremes close after one recording tick and eleven
		// idle ticks.
		queue_word(OP_TICK, 8'h00);
		queue_word(OP_BYTE, 8'h00);
		queue_word(OP_BYTE, 8'hFF);
		queue_word(OP_BYTE, 8'hA5);
		queue_word(OP_BYTE, 8'h5A);
		repeat (12) queue_word(OP_TICK, 8'hFF);
		wait_for_frames();

		// Limit 0: a one-byte frame closes on the first idle tick. The next one-byte
		// frame matches the stale recorded count, so its first tick already closes it.
		write_idle_limit(8'd0);
		queue_word(OP_BYTE, 8'h3C);
		queue_word(OP_TICK, 8'h00);
		queue_word(OP_TICK, 8'h00);
		queue_word(OP_BYTE, 8'hC3);
		queue_word(OP_TICK, 8'h00);
		wait_for_frames();

		// Random frames under several small limits. Each phase ends with enough
		// ticks to flush any partial frame before the next register write.
		foreach (random_limits[p]) begin
			write_idle_limit(random_limits[p]);
			goal = queued_items + 15;
			while (queued_items < goal)
				queue_random_frame();
			repeat (int'(idle_limit_now) + 2)
				queue_word(OP_TICK, 8'($urandom_range(0, 255)));
			wait_for_frames();
		end

		// Back-pressure: the output side holds off while a full-size frame closes and
		// more words keep coming, so the drain stalls and rx_in.ready stays low.
		hold_asks++;
		for (int k = 0; k < FILL_LIMIT; k++)
			queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
		repeat (2) queue_word(OP_TICK, 8'($urandom_range(0, 255)));
		for (int k = 0; k < 20; k++)
			queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
		repeat (2) queue_word(OP_TICK, 8'($urandom_range(0, 255)));
		wait_for_frames();

		// Limit 255: the idle run wraps past 255 and the frame is never closed.
		write_idle_limit(8'd255);
		for (int k = 0; k < 5; k++)
			queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
		repeat (258) queue_word(OP_TICK, 8'($urandom_range(0, 255)));
		wait_for_frames();

		// Limit 0: the run has wrapped to a small value, so the next tick closes the
		// pending frame.
		write_idle_limit(8'd0);
		queue_word(OP_TICK, 8'($urandom_range(0, 255)));
		wait_for_frames();

		// Last part at full rate on both sides, back at the reset limit.
		idling = 1'b0;
		write_idle_limit(8'd10);
		goal = queued_items + 15;
		while (queued_items < goal)
			queue_random_frame();
		repeat (12) queue_word(OP_TICK, 8'($urandom_range(0, 255)));
		wait_for_frames();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule : tb

### sim.f
design/itfr_pkg.sv
design/itfr_if.sv
design/idle_timeout_frame_receiver_top.sv
design/itfr_checker.sv
tb/sv/tb.sv
